[design/pimcs_pkg.sv]
// shared item types and result codes for the pim crossbar scheduler
`default_nettype none
package pimcs_pkg;

	localparam int NUM_INPUTS_DEF  = 8;
	localparam int NUM_OUTPUTS_DEF = 8;
	localparam int COUNT_WIDTH_DEF = 8;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_MASK = 16'hB400;

	localparam logic [3:0] ITER_RESET  = 4'd4;
	localparam logic [7:0] LIMIT_RESET = 8'd16;

	localparam logic [1:0] REG_ITERATIONS  = 2'd0;
	localparam logic [1:0] REG_QUEUE_LIMIT = 2'd1;

	localparam logic [1:0] KIND_ACCEPT  = 2'd0;
	localparam logic [1:0] KIND_DROP    = 2'd1;
	localparam logic [1:0] KIND_MATCH   = 2'd2;
	localparam logic [1:0] KIND_NOMATCH = 2'd3;

	localparam logic CMD_REQUEST   = 1'b0;
	localparam logic CMD_ARBITRATE = 1'b1;

	typedef struct packed {
		logic       command;
		logic [2:0] src_port;
		logic [2:0] dst_port;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] match_input;
		logic [2:0] match_output;
		logic       last;
	} out_item_t;

endpackage
`default_nettype wire

[design/pim_crossbar_scheduler.sv]
// pim crossbar scheduler: voq counters in a synchronous memory, sequential grant/accept rounds
// request item: counter read in idle, checked and written back in ST_REQ once the output is free, one result
// arbitrate item: per round a grant pass over the NUM_OUTPUTS outputs and an accept pass over
// the NUM_INPUTS inputs with a decrement step per match (counter read-modify-write), then a close;
// a new item is taken only in the idle state
// reset: counters read as zero through per-entry valid bits, lfsr to its seed, registers to defaults
`default_nettype none
module pim_crossbar_scheduler import pimcs_pkg::*; #(
	parameter int NUM_INPUTS  = NUM_INPUTS_DEF,
	parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [1:0]  cfg_addr,
	input  wire [7:0]  cfg_wdata,
	input  wire        in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  wire        out_ready,
	output out_item_t  out_item
);

	localparam int NQ  = NUM_INPUTS * NUM_OUTPUTS;
	localparam int AW  = $clog2(NQ);
	localparam int PW  = (NUM_INPUTS > NUM_OUTPUTS) ? NUM_INPUTS : NUM_OUTPUTS;
	localparam int PIW = $clog2(PW);
	localparam int LW  = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
	localparam logic [LW-1:0] MAXC = LW'((1 << COUNT_WIDTH) - 1);
	// exact reciprocals for lfsr mod port count
	localparam int MS_I = 17 + $clog2(NUM_INPUTS);
	localparam int MS_O = 17 + $clog2(NUM_OUTPUTS);
	localparam longint RC_I = ((64'd1 << MS_I) + NUM_INPUTS - 1) / NUM_INPUTS;
	localparam longint RC_O = ((64'd1 << MS_O) + NUM_OUTPUTS - 1) / NUM_OUTPUTS;
	localparam logic [PIW-1:0] LAST_I = PIW'(NUM_INPUTS - 1);
	localparam logic [PIW-1:0] LAST_O = PIW'(NUM_OUTPUTS - 1);

	typedef enum logic [2:0] {ST_IDLE, ST_REQ, ST_GRANT, ST_ACCEPT, ST_DEC, ST_FIN} state_t;

	state_t state_q;
	logic [15:0] lfsr_q;
	logic [3:0] iters_q, round_q;
	logic [7:0] limit_q;
	logic [NUM_INPUTS-1:0] in_m_q;
	logic [NUM_OUTPUTS-1:0] out_m_q, gnt_v_q;
	logic [PIW-1:0] gnt_i_q [NUM_OUTPUTS];
	logic [PIW-1:0] ptr_q, acc_o_q;
	logic [NQ-1:0] valid_q, nz_q;
	logic [AW-1:0] addr_q;
	logic [2:0] src_q, dst_q;
	logic range_q;
	logic pend_v_q;
	logic [2:0] pend_i_q, pend_o_q;
	logic out_valid_q;
	out_item_t out_item_q;

	// counter memory
	logic [COUNT_WIDTH-1:0] cnt_mem [NQ];
	logic [COUNT_WIDTH-1:0] rdata_q;
	logic mem_re, mem_we;
	logic [AW-1:0] mem_ra;
	logic [COUNT_WIDTH-1:0] mem_wd;

	always_ff @(posedge clk) begin
		if (mem_re)
			rdata_q <= cnt_mem[mem_ra];
		if (mem_we)
			cnt_mem[addr_q] <= mem_wd;
	end

	// lfsr mod port count and next lfsr
	logic [47:0] prod_i, prod_o;
	logic [15:0] q_i, q_o, r_i, r_o;
	logic [PIW-1:0] start_i, start_o;
	logic [15:0] lfsr_nx;
	always_comb begin
		prod_i  = 48'(lfsr_q) * 48'(RC_I);
		prod_o  = 48'(lfsr_q) * 48'(RC_O);
		q_i     = 16'(prod_i >> MS_I);
		q_o     = 16'(prod_o >> MS_O);
		r_i     = lfsr_q - 16'(q_i * 16'(NUM_INPUTS));
		r_o     = lfsr_q - 16'(q_o * 16'(NUM_OUTPUTS));
		start_i = PIW'(r_i);
		start_o = PIW'(r_o);
		lfsr_nx = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : 16'h0000);
	end

	// candidate masks and cyclic pick
	logic [PW-1:0] cand_g, cand_a;
	logic [PIW-1:0] pick_g, pick_a;
	logic [PIW:0] idx;
	always_comb begin
		cand_g = '0;
		cand_a = '0;
		for (int i = 0; i < NUM_INPUTS; i++)
			cand_g[i] = !in_m_q[i] && nz_q[AW'(i) * AW'(NUM_OUTPUTS) + AW'(ptr_q)];
		for (int o = 0; o < NUM_OUTPUTS; o++)
			cand_a[o] = !out_m_q[o] && gnt_v_q[o] && (gnt_i_q[o] == ptr_q);
		pick_g = '0;
		pick_a = '0;
		idx = '0;
		for (int k = PW - 1; k >= 0; k--) begin
			if (k < NUM_INPUTS) begin
				idx = (PIW+1)'(start_i) + (PIW+1)'(k);
				if (idx >= (PIW+1)'(NUM_INPUTS))
					idx = idx - (PIW+1)'(NUM_INPUTS);
				if (cand_g[idx[PIW-1:0]])
					pick_g = idx[PIW-1:0];
			end
		end
		for (int k = PW - 1; k >= 0; k--) begin
			if (k < NUM_OUTPUTS) begin
				idx = (PIW+1)'(start_o) + (PIW+1)'(k);
				if (idx >= (PIW+1)'(NUM_OUTPUTS))
					idx = idx - (PIW+1)'(NUM_OUTPUTS);
				if (cand_a[idx[PIW-1:0]])
					pick_a = idx[PIW-1:0];
			end
		end
	end

	logic out_free;
	logic out_load;
	logic in_range;
	logic [AW-1:0] req_a, acc_a;
	logic [COUNT_WIDTH-1:0] cur, dec_v;
	logic [LW-1:0] lim;
	logic req_ok, round_last;
	always_comb begin
		out_free = !out_valid_q || out_ready;
		in_range = (6'(in_item.src_port) < 6'(NUM_INPUTS))
			&& (6'(in_item.dst_port) < 6'(NUM_OUTPUTS));
		req_a = AW'(in_item.src_port) * AW'(NUM_OUTPUTS) + AW'(in_item.dst_port);
		acc_a = AW'(ptr_q) * AW'(NUM_OUTPUTS) + AW'(pick_a);
		cur = valid_q[addr_q] ? rdata_q : '0;
		dec_v = rdata_q - COUNT_WIDTH'(1);
		lim = (LW'(limit_q) < MAXC) ? LW'(limit_q) : MAXC;
		req_ok = range_q && (LW'(cur) < lim);
		round_last = (round_q + 4'd1) == iters_q;
		mem_re = 1'b0;
		mem_ra = req_a;
		mem_we = 1'b0;
		mem_wd = dec_v;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				mem_re = in_valid && (in_item.command == CMD_REQUEST);
			end
			ST_REQ: begin
				mem_we = out_free && req_ok;
				mem_wd = cur + COUNT_WIDTH'(1);
				out_load = out_free;
			end
			ST_ACCEPT: begin
				mem_re = !in_m_q[ptr_q] && (|cand_a);
				mem_ra = acc_a;
			end
			ST_DEC: begin
				mem_we = !pend_v_q || out_free;
				out_load = pend_v_q && out_free;
			end
			ST_FIN: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lfsr_q      <= LFSR_SEED;
			iters_q     <= ITER_RESET;
			limit_q     <= LIMIT_RESET;
			round_q     <= '0;
			in_m_q      <= '0;
			out_m_q     <= '0;
			gnt_v_q     <= '0;
			ptr_q       <= '0;
			valid_q     <= '0;
			nz_q        <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_ITERATIONS)
					iters_q <= cfg_wdata[3:0];
				else if (cfg_addr == REG_QUEUE_LIMIT)
					limit_q <= cfg_wdata;
			end
			// result register: load a new item or drop the one taken
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_item.command == CMD_ARBITRATE) begin
							in_m_q   <= '0;
							out_m_q  <= '0;
							gnt_v_q  <= '0;
							round_q  <= '0;
							ptr_q    <= '0;
							pend_v_q <= 1'b0;
							state_q  <= (iters_q == 4'd0) ? ST_FIN : ST_GRANT;
						end else begin
							src_q   <= in_item.src_port;
							dst_q   <= in_item.dst_port;
							range_q <= in_range;
							addr_q  <= req_a;
							state_q <= ST_REQ;
						end
					end
				end
				ST_REQ: begin
					if (out_free) begin
						out_item_q  <= '{kind: req_ok ? KIND_ACCEPT : KIND_DROP,
							match_input: src_q, match_output: dst_q, last: 1'b1};
						if (req_ok) begin
							valid_q[addr_q] <= 1'b1;
							nz_q[addr_q]    <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_GRANT: begin
					// output ptr_q grants one unmatched requesting input
					if (!out_m_q[ptr_q] && (|cand_g)) begin
						gnt_v_q[ptr_q] <= 1'b1;
						gnt_i_q[ptr_q] <= pick_g;
						lfsr_q         <= lfsr_nx;
					end
					if (ptr_q == LAST_O) begin
						ptr_q   <= '0;
						state_q <= ST_ACCEPT;
					end else
						ptr_q <= ptr_q + PIW'(1);
				end
				ST_ACCEPT: begin
					// input ptr_q accepts one granting output; no conflicts since
					// each output grants a single input
					if (!in_m_q[ptr_q] && (|cand_a)) begin
						lfsr_q          <= lfsr_nx;
						acc_o_q         <= pick_a;
						in_m_q[ptr_q]   <= 1'b1;
						out_m_q[pick_a] <= 1'b1;
						addr_q          <= acc_a;
						state_q         <= ST_DEC;
					end else if (ptr_q == LAST_I) begin
						ptr_q   <= '0;
						gnt_v_q <= '0;
						round_q <= round_q + 4'd1;
						state_q <= round_last ? ST_FIN : ST_GRANT;
					end else
						ptr_q <= ptr_q + PIW'(1);
				end
				ST_DEC: begin
					// counter write-back; previous match leaves with last clear
					if (!pend_v_q || out_free) begin
						nz_q[addr_q] <= (dec_v != '0);
						if (pend_v_q) begin
							out_item_q  <= '{kind: KIND_MATCH, match_input: pend_i_q,
								match_output: pend_o_q, last: 1'b0};
						end
						pend_v_q <= 1'b1;
						pend_i_q <= 3'(ptr_q);
						pend_o_q <= 3'(acc_o_q);
						if (ptr_q == LAST_I) begin
							ptr_q   <= '0;
							gnt_v_q <= '0;
							round_q <= round_q + 4'd1;
							state_q <= round_last ? ST_FIN : ST_GRANT;
						end else begin
							ptr_q   <= ptr_q + PIW'(1);
							state_q <= ST_ACCEPT;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						if (pend_v_q)
							out_item_q <= '{kind: KIND_MATCH, match_input: pend_i_q,
								match_output: pend_o_q, last: 1'b1};
						else
							out_item_q <= '{kind: KIND_NOMATCH, match_input: 3'd0,
								match_output: 3'd0, last: 1'b1};
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
`default_nettype wire
